// ===== rtl/core/pulse_record_analysis_defines.svh =====
// Assertion macros used by the checker.
`ifndef PULSE_RECORD_ANALYSIS_DEFINES_SVH
`define PULSE_RECORD_ANALYSIS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/pra_pkg.sv =====
package pra_pkg;

  localparam int P_W         = 12;
  localparam int IN_SAMPLE_W = 16;
  localparam int TIME_W      = 64;
  localparam int OUT_W       = 24;
  localparam int AVG_W       = 25;
  localparam int STAT_W      = 2;
  localparam int OP_W        = 4;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 168;

  localparam logic [P_W-1:0]   P_RESET = 12'd256;
  localparam logic [OUT_W-1:0] UMAX24  = 24'hFFFFFF;
  localparam logic [AVG_W-1:0] SMAX25  = 25'd16777215;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOPOST = 2'd1;
  localparam logic [STAT_W-1:0] STAT_LONG   = 2'd2;

  // finalisation steps, run in this order
  localparam logic [OP_W-1:0] OP_NP   = 4'd0;
  localparam logic [OP_W-1:0] OP_NPP  = 4'd1;
  localparam logic [OP_W-1:0] OP_PP   = 4'd2;
  localparam logic [OP_W-1:0] OP_T1   = 4'd3;
  localparam logic [OP_W-1:0] OP_MM   = 4'd4;
  localparam logic [OP_W-1:0] OP_T3   = 4'd5;
  localparam logic [OP_W-1:0] OP_MP   = 4'd6;
  localparam logic [OP_W-1:0] OP_T2   = 4'd7;
  localparam logic [OP_W-1:0] OP_RDIV = 4'd8;
  localparam logic [OP_W-1:0] OP_SQRT = 4'd9;
  localparam logic [OP_W-1:0] OP_AVP  = 4'd10;
  localparam logic [OP_W-1:0] OP_AVN  = 4'd11;
  localparam logic [OP_W-1:0] OP_ADIV = 4'd12;
  localparam logic [OP_W-1:0] OP_PKP  = 4'd13;
  localparam logic [OP_W-1:0] OP_PDIV = 4'd14;
  localparam logic [OP_W-1:0] OP_BDIV = 4'd15;
  localparam logic [OP_W-1:0] OP_FIRST = OP_NP;
  localparam logic [OP_W-1:0] OP_LAST  = OP_BDIV;

  typedef struct packed {
    logic            start;
    logic            load;
    logic [OP_W-1:0] op;
  } pra_cmd_t;

  typedef struct packed {
    logic done;
    logic rec_ok;
  } pra_stat_t;

endpackage

// ===== rtl/core/pra_mul.sv =====
module pra_mul #(
  parameter int A_W = 64,
  parameter int B_W = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  output logic           done,
  output logic [A_W-1:0] prod
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]   a_r;
  logic [B_W-1:0]   b_r;
  logic [A_W-1:0]   prod_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        prod_r <= '0;
        cnt_r  <= CNT_W'(B_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (b_r[0]) prod_r <= prod_r + a_r;
        a_r   <= {a_r[A_W-2:0], 1'b0};
        b_r   <= {1'b0, b_r[B_W-1:1]};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

// ===== rtl/core/pra_div.sv =====
module pra_div #(
  parameter int DV_W = 96,
  parameter int D_W  = 40
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DV_W-1:0] dividend,
  input  logic [D_W-1:0]  divisor,
  output logic            done,
  output logic [DV_W-1:0] quo,
  output logic            rem_nz
);

  localparam int CNT_W = $clog2(DV_W + 1);

  logic [DV_W-1:0]  quo_r;
  logic [D_W-1:0]   rem_r;
  logic [D_W-1:0]   dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             ge;

  assign trial = {rem_r, quo_r[DV_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
        cnt_r  <= CNT_W'(DV_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
        quo_r <= {quo_r[DV_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign quo    = quo_r;
  assign rem_nz = |rem_r;

endmodule

// ===== rtl/core/pra_sqrt.sv =====
module pra_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [2*pra_pkg::OUT_W-1:0] v,
  output logic                       done,
  output logic [pra_pkg::OUT_W-1:0]  root
);

  localparam int W     = pra_pkg::OUT_W;
  localparam int CNT_W = $clog2(W + 1);

  logic [2*W-1:0]   v_r;
  logic [W:0]       rem_r;
  logic [W-1:0]     root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [W+2:0]     r2;
  logic [W+2:0]     trial;
  logic [W+2:0]     diff;
  logic             ge;

  assign r2    = {rem_r, v_r[2*W-1:2*W-2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = r2 >= trial;
  assign diff  = r2 - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= v;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CNT_W'(W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= ge ? diff[W:0] : r2[W:0];
        root_r <= {root_r[W-2:0], ge};
        v_r    <= {v_r[2*W-3:0], 2'b00};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/core/pra_ctrl.sv =====
module pra_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tlast,
  input  logic                out_tready,
  input  pra_pkg::pra_stat_t  stat,
  output logic                in_tready,
  output logic                in_acc,
  output logic                out_tvalid,
  output pra_pkg::pra_cmd_t   cmd
);

  localparam logic [1:0] S_ACC   = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_LOAD  = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [pra_pkg::OP_W-1:0] op_r, op_nxt;
  logic                     out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_ACC);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.start     = 1'b0;
    cmd.load      = 1'b0;
    cmd.op        = op_r;
    case (state_r)
      S_ACC: begin
        if (in_acc && in_tlast) begin
          state_nxt = S_ISSUE;
          op_nxt    = pra_pkg::OP_FIRST;
        end
      end
      S_ISSUE: begin
        if (stat.rec_ok) begin
          cmd.start = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_WAIT: begin
        if (stat.done) begin
          if (op_r == pra_pkg::OP_LAST) begin
            state_nxt = S_LOAD;
          end else begin
            op_nxt    = pra_pkg::OP_W'(op_r + 1'b1);
            state_nxt = S_ISSUE;
          end
        end
      end
      S_LOAD: begin
        if (!out_valid_r || out_tready) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_ACC;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      op_r        <= pra_pkg::OP_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/pra_dp.sv =====
module pra_dp #(
  parameter int MAX_SAMPLES = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [pra_pkg::P_W-1:0]           cfg_wr_data,
  input  logic                              in_acc,
  input  logic [pra_pkg::IN_SAMPLE_W-1:0]   in_sample,
  input  logic                              in_last,
  input  logic [pra_pkg::TIME_W-1:0]        in_time,
  input  pra_pkg::pra_cmd_t                 cmd,
  output pra_pkg::pra_stat_t                stat,
  output logic [pra_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [pra_pkg::STAT_W-1:0]        out_tuser
);

  localparam int P_W     = pra_pkg::P_W;
  localparam int OUT_W   = pra_pkg::OUT_W;
  localparam int AVG_W   = pra_pkg::AVG_W;
  localparam int IDX_W   = $clog2(MAX_SAMPLES + 2);
  localparam int SUM_W   = SAMPLE_BITS + IDX_W;
  localparam int SQ_W    = 2 * SAMPLE_BITS + IDX_W;
  localparam int T_W     = 2 * SUM_W + IDX_W + 2 * P_W + 1;
  localparam int B_W     = (SUM_W > 2 * P_W) ? SUM_W : 2 * P_W;
  localparam int D_W     = IDX_W + 2 * P_W;
  localparam int DV_W    = T_W + 16;
  localparam int CW      = ((IDX_W > P_W) ? IDX_W : P_W) + 2;
  localparam int SQI_W   = 2 * OUT_W;

  logic [P_W-1:0]         pcfg_r;
  logic [P_W-1:0]         p;
  logic [31:0]            sample_ext;
  logic [SAMPLE_BITS-1:0] x;
  logic [2*SAMPLE_BITS-1:0] xsq;
  logic [IDX_W-1:0]       idx_r;
  logic [SUM_W-1:0]       pre_r, post_r;
  logic [SQ_W-1:0]        sq_r;
  logic [SAMPLE_BITS-1:0] pk_r;
  logic [pra_pkg::TIME_W-1:0] time_r;
  logic [CW-1:0]          idx_cw, p_cw, max_cw;
  logic [IDX_W-1:0]       n;
  logic [pra_pkg::STAT_W-1:0] stat_code;

  logic [D_W-1:0]         np_r, npp_r;
  logic [2*P_W-1:0]       pp_r;
  logic [T_W-1:0]         acc_r, tmp_r, mag_r;
  logic                   neg_r;
  logic [SQI_W-1:0]       sqi_r;
  logic [OUT_W-1:0]       base_r, rms_r;
  logic [AVG_W-1:0]       avg_r, pkv_r;

  logic                   is_mul, is_div, is_sqrt;
  logic [T_W-1:0]         mul_a;
  logic [B_W-1:0]         mul_b;
  logic                   mul_done;
  logic [T_W-1:0]         prod;
  logic [DV_W-1:0]        dvd;
  logic [D_W-1:0]         dvs;
  logic                   div_done;
  logic [DV_W-1:0]        quo;
  logic                   rem_nz;
  logic                   sqrt_done;
  logic [OUT_W-1:0]       root;
  logic [DV_W:0]          qmag;
  logic [AVG_W-1:0]       qsat;
  logic [AVG_W-1:0]       sval;

  assign p          = (pcfg_r == '0) ? P_W'(1) : pcfg_r;
  assign sample_ext = {{(32 - pra_pkg::IN_SAMPLE_W){1'b0}}, in_sample};
  assign x          = sample_ext[SAMPLE_BITS-1:0];
  assign xsq        = (2 * SAMPLE_BITS)'(x) * (2 * SAMPLE_BITS)'(x);
  assign idx_cw     = CW'(idx_r);
  assign p_cw       = CW'(p);
  assign max_cw     = CW'(MAX_SAMPLES);
  assign n          = IDX_W'(idx_cw - p_cw - CW'(1));

  always_comb begin
    if (idx_cw > max_cw) stat_code = pra_pkg::STAT_LONG;
    else if (idx_cw <= p_cw + CW'(1)) stat_code = pra_pkg::STAT_NOPOST;
    else stat_code = pra_pkg::STAT_OK;
  end

  always_comb begin
    is_mul  = 1'b0;
    is_div  = 1'b0;
    is_sqrt = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    dvd     = '0;
    dvs     = '0;
    case (cmd.op)
      pra_pkg::OP_NP:   begin is_mul = 1'b1; mul_a = T_W'(n);     mul_b = B_W'(p);      end
      pra_pkg::OP_NPP:  begin is_mul = 1'b1; mul_a = T_W'(np_r);  mul_b = B_W'(p);      end
      pra_pkg::OP_PP:   begin is_mul = 1'b1; mul_a = T_W'(p);     mul_b = B_W'(p);      end
      pra_pkg::OP_T1:   begin is_mul = 1'b1; mul_a = T_W'(sq_r);  mul_b = B_W'(pp_r);   end
      pra_pkg::OP_MM:   begin is_mul = 1'b1; mul_a = T_W'(pre_r); mul_b = B_W'(pre_r);  end
      pra_pkg::OP_T3:   begin is_mul = 1'b1; mul_a = tmp_r;       mul_b = B_W'(n);      end
      pra_pkg::OP_MP:   begin is_mul = 1'b1; mul_a = T_W'(pre_r); mul_b = B_W'(p);      end
      pra_pkg::OP_T2:   begin is_mul = 1'b1; mul_a = tmp_r;       mul_b = B_W'(post_r); end
      pra_pkg::OP_AVP:  begin is_mul = 1'b1; mul_a = T_W'(post_r); mul_b = B_W'(p);     end
      pra_pkg::OP_AVN:  begin is_mul = 1'b1; mul_a = T_W'(pre_r); mul_b = B_W'(n);      end
      pra_pkg::OP_PKP:  begin is_mul = 1'b1; mul_a = T_W'(pk_r);  mul_b = B_W'(p);      end
      pra_pkg::OP_SQRT: is_sqrt = 1'b1;
      pra_pkg::OP_RDIV: begin is_div = 1'b1; dvd = {acc_r, 16'd0};         dvs = npp_r;     end
      pra_pkg::OP_ADIV: begin is_div = 1'b1; dvd = DV_W'({mag_r, 8'd0});   dvs = np_r;      end
      pra_pkg::OP_PDIV: begin is_div = 1'b1; dvd = DV_W'({mag_r, 8'd0});   dvs = D_W'(p);   end
      pra_pkg::OP_BDIV: begin is_div = 1'b1; dvd = DV_W'({pre_r, 8'd0});   dvs = D_W'(p);   end
      default: ;
    endcase
  end

  pra_mul #(.A_W(T_W), .B_W(B_W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(cmd.start && is_mul),
    .a(mul_a), .b(mul_b), .done(mul_done), .prod(prod)
  );

  pra_div #(.DV_W(DV_W), .D_W(D_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.start && is_div),
    .dividend(dvd), .divisor(dvs), .done(div_done), .quo(quo), .rem_nz(rem_nz)
  );

  pra_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(cmd.start && is_sqrt),
    .v(sqi_r), .done(sqrt_done), .root(root)
  );

  // floor of a signed quotient, then clamp to the symmetric range
  assign qmag = {1'b0, quo} + (DV_W + 1)'(neg_r && rem_nz);
  assign qsat = (qmag > (DV_W + 1)'(pra_pkg::SMAX25)) ? pra_pkg::SMAX25 : qmag[AVG_W-1:0];
  assign sval = neg_r ? AVG_W'(-qsat) : qsat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcfg_r <= pra_pkg::P_RESET;
      idx_r  <= '0;
      pre_r  <= '0;
      post_r <= '0;
      sq_r   <= '0;
      pk_r   <= '0;
    end else begin
      if (cfg_wr_en) pcfg_r <= cfg_wr_data;
      if (in_acc) begin
        if (idx_cw < max_cw) begin
          if (idx_cw < p_cw) begin
            pre_r <= pre_r + SUM_W'(x);
          end else if (idx_cw > p_cw) begin
            post_r <= post_r + SUM_W'(x);
            sq_r   <= sq_r + SQ_W'(xsq);
            if (x > pk_r) pk_r <= x;
          end
        end
        if (idx_cw <= max_cw) idx_r <= idx_r + 1'b1;
      end else if (cmd.load) begin
        idx_r  <= '0;
        pre_r  <= '0;
        post_r <= '0;
        sq_r   <= '0;
        pk_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_last) time_r <= in_time;
    if (mul_done) begin
      case (cmd.op)
        pra_pkg::OP_NP:  np_r  <= D_W'(prod);
        pra_pkg::OP_NPP: npp_r <= D_W'(prod);
        pra_pkg::OP_PP:  pp_r  <= (2 * P_W)'(prod);
        pra_pkg::OP_T1:  acc_r <= prod;
        pra_pkg::OP_MM:  tmp_r <= prod;
        pra_pkg::OP_T3:  acc_r <= acc_r + prod;
        pra_pkg::OP_MP:  tmp_r <= prod;
        pra_pkg::OP_T2:  acc_r <= acc_r - {prod[T_W-2:0], 1'b0};
        pra_pkg::OP_AVP: tmp_r <= prod;
        pra_pkg::OP_AVN: begin
          neg_r <= tmp_r < prod;
          mag_r <= (tmp_r < prod) ? prod - tmp_r : tmp_r - prod;
        end
        pra_pkg::OP_PKP: begin
          neg_r <= prod < T_W'(pre_r);
          mag_r <= (prod < T_W'(pre_r)) ? T_W'(pre_r) - prod : prod - T_W'(pre_r);
        end
        default: ;
      endcase
    end
    if (div_done) begin
      case (cmd.op)
        pra_pkg::OP_RDIV: sqi_r <= (|quo[DV_W-1:SQI_W]) ? {SQI_W{1'b1}} : quo[SQI_W-1:0];
        pra_pkg::OP_ADIV: avg_r <= sval;
        pra_pkg::OP_PDIV: pkv_r <= sval;
        pra_pkg::OP_BDIV: base_r <= (quo > DV_W'(pra_pkg::UMAX24)) ? pra_pkg::UMAX24
                                                                  : quo[OUT_W-1:0];
        default: ;
      endcase
    end
    if (sqrt_done) rms_r <= root;
    if (cmd.load) begin
      out_tuser <= stat_code;
      if (stat_code == pra_pkg::STAT_OK) begin
        out_tdata <= {6'd0, time_r, rms_r, pkv_r, avg_r, base_r};
      end else begin
        out_tdata <= {6'd0, time_r, {(2 * OUT_W + 2 * AVG_W){1'b0}}};
      end
    end
  end

  assign stat.done   = mul_done || div_done || sqrt_done;
  assign stat.rec_ok = (stat_code == pra_pkg::STAT_OK);

endmodule

// ===== rtl/core/pulse_record_analysis.sv =====
// Channel  Dir  Words
// in_      in   sample + timestamp, tlast ends a record
// out_     out  one analysis result per record, tuser = status
// cfg_     in   presample count write
//
// Samples are taken one per cycle while no record is being finished.
// After the last sample, a serial multiply / divide / square-root sequencer
// holds in_tready low while it runs; a record with a failed status skips it.
// A finished result waits in the output register while the next record streams in;
// the next result holds in_tready low until that word has left.
// Reset is synchronous, active low; presample count returns to 256.
module pulse_record_analysis #(
  parameter int MAX_SAMPLES = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [pra_pkg::P_W-1:0]           cfg_wr_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pra_pkg::IN_TDATA_W-1:0]    in_tdata,   // sample[15:0], record_time[79:16]
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // baseline[23:0], mean_excess[48:24], peak_excess[73:49], rms_spread[97:74],
  // record_stamp[161:98], zero fill
  output logic [pra_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [pra_pkg::STAT_W-1:0]        out_tuser   // status
);

  pra_pkg::pra_cmd_t  cmd;
  pra_pkg::pra_stat_t stat;
  logic               in_acc;

  pra_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tlast(in_tlast),
    .out_tready(out_tready), .stat(stat), .in_tready(in_tready), .in_acc(in_acc),
    .out_tvalid(out_tvalid), .cmd(cmd)
  );

  pra_dp #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_acc(in_acc), .in_sample(in_tdata[pra_pkg::IN_SAMPLE_W-1:0]), .in_last(in_tlast),
    .in_time(in_tdata[pra_pkg::IN_TDATA_W-1:pra_pkg::IN_SAMPLE_W]),
    .cmd(cmd), .stat(stat), .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule

// ===== rtl/core/pra_checker.sv =====
`include "pulse_record_analysis_defines.svh"

module pra_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         in_tlast,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [167:0] out_tdata,
  input logic [1:0]   out_tuser
);

  `PRA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output word dropped or changed while stalled")
  `PRA_ASSERT_NOW(a_status_code, out_tvalid, out_tuser <= pra_pkg::STAT_LONG, "unknown status")
  `PRA_ASSERT_NOW(a_bad_zero, out_tvalid && out_tuser != pra_pkg::STAT_OK, out_tdata[97:0] == 98'd0, "failed record carries values")
  `PRA_ASSERT_NEXT(a_busy_after_last, in_tvalid && in_tready && in_tlast, !in_tready, "input taken during record finish")

endmodule

bind pulse_record_analysis pra_checker u_pra_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tlast(in_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);

// ===== sim/pulse_record_analysis_tb.sv =====
`timescale 1ns / 1ps

module pulse_record_analysis_tb;

  localparam int MAX_SAMPLES = 4096;
  localparam int FINISH_WAIT = 1000;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [pra_pkg::OUT_W-1:0]  baseline;
    logic [pra_pkg::AVG_W-1:0]  mean_excess;
    logic [pra_pkg::AVG_W-1:0]  peak_excess;
    logic [pra_pkg::OUT_W-1:0]  rms_spread;
    logic [pra_pkg::TIME_W-1:0] record_stamp;
    logic [pra_pkg::STAT_W-1:0] status;
  } analysis_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic [pra_pkg::P_W-1:0]         cfg_wr_data;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [pra_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            in_tlast;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [pra_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [pra_pkg::STAT_W-1:0]      out_tuser;

  analysis_t   expected_results[$];
  logic [pra_pkg::P_W-1:0] presamples;
  int          rec_index;
  logic [63:0] pre_acc, post_acc, square_acc, peak_hold;
  int          mismatches = 0;
  int          records_sent = 0, samples_sent = 0, results_seen = 0;
  longint      cycle_count = 0;
  bit          no_idle;

  pulse_record_analysis u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 19);
  end

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic [pra_pkg::AVG_W-1:0] clamp_s25(longint v);
    if (v > 16777215) v = 16777215;
    if (v < -16777215) v = -16777215;
    return v[pra_pkg::AVG_W-1:0];
  endfunction

  function automatic void clear_record();
    rec_index = 0;
    pre_acc = 0;
    post_acc = 0;
    square_acc = 0;
    peak_hold = 0;
  endfunction

  // accumulate one accepted word; on record end queue the analysis
  function automatic void analyse_word(logic [15:0] sample, logic last, logic [63:0] stamp);
    analysis_t   r;
    longint      p, n, len;
    logic [63:0] x, base, quo;
    logic [127:0] tot, den;
    p = (presamples == 0) ? 1 : longint'(presamples);
    x = 64'(sample);
    if (rec_index < MAX_SAMPLES) begin
      if (rec_index < p) begin
        pre_acc = pre_acc + x;
      end else if (rec_index > p) begin
        post_acc = post_acc + x;
        square_acc = square_acc + x * x;
        if (x > peak_hold) peak_hold = x;
      end
    end
    if (rec_index <= MAX_SAMPLES) rec_index++;
    if (!last) return;
    r = '{default: '0};
    r.record_stamp = stamp;
    len = longint'(rec_index);
    if (len > MAX_SAMPLES) begin
      r.status = pra_pkg::STAT_LONG;
    end else if (len <= p + 1) begin
      r.status = pra_pkg::STAT_NOPOST;
    end else begin
      n = len - p - 1;
      base = (pre_acc << 8) / p;
      r.baseline = (base > 64'hFFFFFF) ? pra_pkg::UMAX24 : base[pra_pkg::OUT_W-1:0];
      r.mean_excess = clamp_s25(floor_div(longint'(post_acc) * p * 256
                                           - longint'(pre_acc) * n * 256, n * p));
      r.peak_excess = clamp_s25(floor_div(longint'(peak_hold) * p * 256
                                           - longint'(pre_acc) * 256, p));
      tot = 128'(square_acc) * 128'(p) * 128'(p) + 128'(n) * 128'(pre_acc) * 128'(pre_acc)
            - 128'(2) * 128'(pre_acc) * 128'(p) * 128'(post_acc);
      tot = tot << 16;
      den = 128'(n) * 128'(p) * 128'(p);
      tot = tot / den;
      quo = (tot[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : tot[63:0];
      base = isqrt(quo);
      r.rms_spread = (base > 64'hFFFFFF) ? pra_pkg::UMAX24 : base[pra_pkg::OUT_W-1:0];
      r.status = pra_pkg::STAT_OK;
    end
    expected_results.push_back(r);
    clear_record();
  endfunction

  always @(posedge clk) begin
    analysis_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result word with no analysis pending");
        mismatches++;
      end else begin
        e = expected_results.pop_front();
        if (out_tdata[23:0] !== e.baseline) begin
          $error("baseline exp %h got %h", e.baseline, out_tdata[23:0]);
          mismatches++;
        end
        if (out_tdata[48:24] !== e.mean_excess) begin
          $error("mean_excess exp %h got %h", e.mean_excess, out_tdata[48:24]);
          mismatches++;
        end
        if (out_tdata[73:49] !== e.peak_excess) begin
          $error("peak_excess exp %h got %h", e.peak_excess, out_tdata[73:49]);
          mismatches++;
        end
        if (out_tdata[97:74] !== e.rms_spread) begin
          $error("rms_spread exp %h got %h", e.rms_spread, out_tdata[97:74]);
          mismatches++;
        end
        if (out_tdata[161:98] !== e.record_stamp) begin
          $error("record_stamp exp %h got %h", e.record_stamp, out_tdata[161:98]);
          mismatches++;
        end
        if (out_tuser !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_tuser);
          mismatches++;
        end
      end
    end
  end

  task automatic send_word(logic [15:0] sample, logic last, logic [63:0] stamp);
    if (!no_idle && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 19);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {stamp, sample};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    analyse_word(sample, last, stamp);
    samples_sent++;
    if (last) records_sent++;
  endtask

  // kind 0 random, 1 all max, 2 all zero, 3 high baseline then low tail, 4 pulse
  task automatic send_record(int len, int kind);
    logic [15:0] s;
    int          p;
    logic [15:0] level;
    p = (presamples == 0) ? 1 : int'(presamples);
    level = 16'($urandom_range(4000, 200));
    for (int i = 0; i < len; i++) begin
      case (kind)
        1: s = 16'hFFFF;
        2: s = 16'h0000;
        3: s = (i < p) ? 16'hFFFF : 16'(($urandom_range(3)));
        4: begin
          if (i <= p) s = 16'(level + $urandom_range(15));
          else s = 16'(level + $urandom_range(60000 - level) / (1 + i - p));
        end
        default: s = 16'($urandom);
      endcase
      send_word(s, i == len - 1, {$urandom, $urandom});
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (FINISH_WAIT) @(posedge clk);
  endtask

  task automatic write_presamples(logic [pra_pkg::P_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    presamples = value;
  endtask

  task automatic test_reset_count();
    send_record(258, 4);
  endtask

  task automatic test_short_records();
    write_presamples(12'd1);
    send_record(1, 0);
    send_record(2, 1);
    send_record(3, 1);
    send_record(3, 2);
    send_record(5, 3);
    send_record(6, 4);
    write_presamples(12'd0);
    send_record(2, 0);
    send_record(4, 1);
  endtask

  task automatic test_length_limits();
    write_presamples(12'd8);
    send_record(9, 0);
    send_record(10, 4);
    send_record(8, 1);
  endtask

  task automatic test_random_records();
    int target;
    target = samples_sent + 280;
    while (samples_sent < target) begin
      if ($urandom_range(9) == 0) write_presamples(pra_pkg::P_W'($urandom_range(8, 1)));
      no_idle = (samples_sent % 200) < 50;
      if ($urandom_range(99) < 80) send_record($urandom_range(presamples + 12, 1),
                                               $urandom_range(4, 3));
      else send_record($urandom_range(40, 1), $urandom_range(2, 0));
    end
    no_idle = 1'b0;
  endtask

  task automatic test_pause_for_results();
    send_record(presamples + 5, 4);
    drain();
    send_record(presamples + 3, 0);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    no_idle = 1'b0;
    presamples = pra_pkg::P_RESET;
    clear_record();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_count();
    test_short_records();
    test_length_limits();
    test_random_records();
    test_pause_for_results();
    drain();
    $display("Sent %0d samples in %0d records, checked %0d results,", samples_sent,
             records_sent, results_seen);
    $display("presample counts 0 to 256, short and empty records, random pulses with stalls.");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pra_pkg.sv
rtl/core/pra_mul.sv
rtl/core/pra_div.sv
rtl/core/pra_sqrt.sv
rtl/core/pra_ctrl.sv
rtl/core/pra_dp.sv
rtl/core/pulse_record_analysis.sv
rtl/core/pra_checker.sv
sim/pulse_record_analysis_tb.sv
